FILE: rtl/dfvo_pkg.sv
// ----------------------------------------------------------------------------
// dfvo_pkg: shared types and codes for the depth-first visit order block
// Holds the request and result payload structs, the operation and register
// codes, the controller states and the command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dfvo_pkg;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_WRITE_EDGE  = 2'd0,
    OP_WRITE_LABEL = 2'd1,
    OP_START       = 2'd2
  } op_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NULL_EDGE    = 2'd0;
  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd1;

  // Fixed field widths.
  localparam int unsigned IDX_BITS     = 6;
  localparam int unsigned WGT_BITS     = 16;
  localparam int unsigned LBL_BITS     = 32;
  localparam int unsigned VCOUNT_BITS  = 7;

  // One input request.
  typedef struct packed {
    logic [1:0]           operation;
    logic [5:0]           row;
    logic [5:0]           column;
    logic signed [15:0]   weight;
    logic signed [31:0]   label;
    logic [5:0]           origin;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [5:0]           vertex_index;
    logic signed [31:0]   vertex_label;
    logic                 bad_origin;
    logic                 last;
  } out_rsp_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAD,
    ST_SCAN,
    ST_PUSH,
    ST_LBL,
    ST_EMIT,
    ST_POP,
    ST_POP2
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_bad;
    logic scan;
    logic push;
    logic emit;
    logic pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_ok;
    logic start_bad;
    logic found;
    logic exhausted;
    logic depth_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/dfvo_ram.sv
// ----------------------------------------------------------------------------
// dfvo_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dfvo_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/dfvo_ctrl.sv
// ----------------------------------------------------------------------------
// dfvo_ctrl: traversal controller
// State machine that sequences request intake, the neighbor scan, stack
// push and pop, and result emission by commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dfvo_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire dfvo_pkg::status_t status_i,
  output      dfvo_pkg::cmd_t    cmd_o
);

  dfvo_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfvo_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dfvo_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.start_bad) begin
          state_d = dfvo_pkg::ST_BAD;
        end else if (in_valid_i && status_i.start_ok) begin
          state_d = dfvo_pkg::ST_SCAN;
        end
      end
      dfvo_pkg::ST_BAD: begin
        if (status_i.out_free) begin
          state_d = dfvo_pkg::ST_IDLE;
        end
      end
      dfvo_pkg::ST_SCAN: begin
        if (status_i.found) begin
          state_d = dfvo_pkg::ST_PUSH;
        end else if (status_i.exhausted && status_i.depth_zero) begin
          state_d = dfvo_pkg::ST_LBL;
        end else if (status_i.exhausted) begin
          state_d = dfvo_pkg::ST_POP;
        end
      end
      dfvo_pkg::ST_PUSH: state_d = dfvo_pkg::ST_LBL;
      dfvo_pkg::ST_LBL:  state_d = dfvo_pkg::ST_EMIT;
      dfvo_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.depth_zero ? dfvo_pkg::ST_IDLE : dfvo_pkg::ST_SCAN;
        end
      end
      dfvo_pkg::ST_POP:  state_d = dfvo_pkg::ST_POP2;
      dfvo_pkg::ST_POP2: state_d = dfvo_pkg::ST_SCAN;
      default:           state_d = dfvo_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      dfvo_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      dfvo_pkg::ST_BAD:  cmd_o.load_bad = 1'b1;
      dfvo_pkg::ST_SCAN: cmd_o.scan     = 1'b1;
      dfvo_pkg::ST_PUSH: cmd_o.push     = 1'b1;
      dfvo_pkg::ST_EMIT: cmd_o.emit     = 1'b1;
      dfvo_pkg::ST_POP2: cmd_o.pop      = 1'b1;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/dfvo_dp.sv
// ----------------------------------------------------------------------------
// dfvo_dp: traversal datapath
// Configuration registers, edge/label/stack memories, visited marks, scan
// pointers and the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dfvo_dp #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned WEIGHT_BITS  = 16,
  parameter int unsigned LABEL_BITS   = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire dfvo_pkg::in_req_t  in_req_i,
  input  wire dfvo_pkg::cmd_t     cmd_i,
  output      dfvo_pkg::status_t  status_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      dfvo_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SW  = VW + CW;
  localparam int unsigned EAW = 2 * VW;

  // Configuration registers.
  logic [15:0] null_q;
  logic [6:0]  vcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      null_q   <= '0;
      vcount_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == dfvo_pkg::CFG_NULL_EDGE) begin
        null_q <= cfg_data_i;
      end else if (cfg_index_i == dfvo_pkg::CFG_VERTEX_COUNT) begin
        vcount_q <= cfg_data_i[6:0];
      end
    end
  end

  // Effective vertex count, saturated to the matrix size.
  logic [CW-1:0] n;
  assign n = (9'(vcount_q) > 9'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_q);

  logic [WEIGHT_BITS-1:0] null_w;
  assign null_w = WEIGHT_BITS'(null_q);

  // Request decode.
  logic is_start, row_ok, col_ok, origin_bad;
  assign is_start   = (in_req_i.operation == dfvo_pkg::OP_START);
  assign row_ok     = 9'(in_req_i.row) < 9'(MAX_VERTICES);
  assign col_ok     = 9'(in_req_i.column) < 9'(MAX_VERTICES);
  assign origin_bad = 9'(in_req_i.origin) >= 9'(n);

  // Traversal registers.
  logic [VW-1:0]           cur_q, cur_d;
  logic [CW-1:0]           j_q, j_d;
  logic                    rd_v_q, rd_v_d;
  logic [VW-1:0]           rd_j_q, rd_j_d;
  logic [CW-1:0]           depth_q, depth_d;
  logic [VW-1:0]           pend_q, pend_d;
  logic [5:0]              orig_q, orig_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  dfvo_pkg::out_rsp_t   out_q, out_d;
  logic                 out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Memory ports.
  logic [WEIGHT_BITS-1:0] edge_rdata;
  logic [LABEL_BITS-1:0]  label_rdata;
  logic [SW-1:0]          stack_rdata;
  logic                   edge_we, label_we;

  assign edge_we  = cmd_i.accept && (in_req_i.operation == dfvo_pkg::OP_WRITE_EDGE)
                    && row_ok && col_ok;
  assign label_we = cmd_i.accept && (in_req_i.operation == dfvo_pkg::OP_WRITE_LABEL)
                    && row_ok;

  dfvo_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (2 ** EAW)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i ({VW'(in_req_i.row), VW'(in_req_i.column)}),
    .wdata_i (WEIGHT_BITS'($unsigned(in_req_i.weight))),
    .raddr_i ({cur_q, VW'(j_q)}),
    .rdata_o (edge_rdata)
  );

  dfvo_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (label_we),
    .waddr_i (VW'(in_req_i.row)),
    .wdata_i (LABEL_BITS'($unsigned(in_req_i.label))),
    .raddr_i (pend_q),
    .rdata_o (label_rdata)
  );

  // The stack holds the saved frames of the vertices above the current one.
  dfvo_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_VERTICES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (VW'(depth_q)),
    .wdata_i ({cur_q, CW'(rd_j_q) + CW'(1)}),
    .raddr_i (VW'(depth_q - CW'(1))),
    .rdata_o (stack_rdata)
  );

  // Scan status: the entry read last cycle is an edge to an unvisited vertex.
  logic found, exhausted;
  assign found     = rd_v_q && (edge_rdata != null_w) && !visited_q[rd_j_q];
  assign exhausted = !rd_v_q && (j_q >= n);

  assign status_o.start_ok   = is_start && !origin_bad;
  assign status_o.start_bad  = is_start && origin_bad;
  assign status_o.found      = found;
  assign status_o.exhausted  = exhausted;
  assign status_o.depth_zero = (depth_q == '0);
  assign status_o.out_free   = out_free;

  // Next-value logic of the traversal registers and the output register.
  always_comb begin
    cur_d       = cur_q;
    j_d         = j_q;
    rd_v_d      = rd_v_q;
    rd_j_d      = rd_j_q;
    depth_d     = depth_q;
    pend_d      = pend_q;
    orig_d      = orig_q;
    visited_d   = visited_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // A taken result frees the output register.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Start request: clear the marks and seed the walk at the origin.
    if (cmd_i.accept && is_start) begin
      orig_d = in_req_i.origin;
      if (!origin_bad) begin
        visited_d                       = '0;
        visited_d[VW'(in_req_i.origin)] = 1'b1;
        cur_d                           = VW'(in_req_i.origin);
        pend_d                          = VW'(in_req_i.origin);
        j_d                             = '0;
        rd_v_d                          = 1'b0;
        depth_d                         = '0;
      end
    end

    // Bad origin gives one error result.
    if (cmd_i.load_bad && out_free) begin
      out_valid_d        = 1'b1;
      out_d.vertex_index = orig_q;
      out_d.vertex_label = '0;
      out_d.bad_origin   = 1'b1;
      out_d.last         = 1'b1;
    end

    // Neighbor scan: one matrix read issued per cycle until a neighbor is found, compared in the next cycle.
    if (cmd_i.scan && !found) begin
      if (j_q < n) begin
        rd_v_d = 1'b1;
        rd_j_d = VW'(j_q);
        j_d    = j_q + CW'(1);
      end else begin
        rd_v_d = 1'b0;
      end
    end

    // Descend into the found neighbor.
    if (cmd_i.push) begin
      visited_d[rd_j_q] = 1'b1;
      cur_d             = rd_j_q;
      j_d               = '0;
      rd_v_d            = 1'b0;
      depth_d           = depth_q + CW'(1);
    end

    // Deliver the pending vertex; the final one carries the last flag.
    if (cmd_i.emit && out_free) begin
      out_valid_d        = 1'b1;
      out_d.vertex_index = 6'(pend_q);
      out_d.vertex_label = 32'(label_rdata);
      out_d.bad_origin   = 1'b0;
      out_d.last         = (depth_q == '0);
      pend_d             = cur_q;
    end

    // Resume the parent frame.
    if (cmd_i.pop) begin
      cur_d   = stack_rdata[SW-1:CW];
      j_d     = stack_rdata[CW-1:0];
      rd_v_d  = 1'b0;
      depth_d = depth_q - CW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      depth_q     <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q      <= rd_v_d;
      depth_q     <= depth_d;
      visited_q   <= visited_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    j_q    <= j_d;
    rd_j_q <= rd_j_d;
    pend_q <= pend_d;
    orig_q <= orig_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

FILE: rtl/depth_first_visit_order.sv
// ----------------------------------------------------------------------------
// depth_first_visit_order: preorder depth-first walk over an adjacency matrix
// Requests write edge weights or vertex labels, or start a walk from an
// origin; each visited vertex comes out as one result.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i / in_stall_o, results leave on out_valid_o /
//   out_stall_i; a side moves a request at an edge with valid high and stall
//   low. The null-edge weight and vertex count are written on the cfg port,
//   which is always ready; the user must write them only while no walk is in
//   progress, and the block does not enforce this. Write requests give no
//   result. A start request gives one result per reached vertex in preorder,
//   the final one flagged last; an origin at or beyond the vertex count gives
//   a single error result. The neighbor scan reads one matrix entry per cycle
//   while it scans, through the edge memory's single read port, and each
//   stack push, pop and result has its own controller states. Each result is
//   held until the next vertex is found, so the first one appears once the
//   origin's first neighbor is found or its scan ends. Requests are stalled
//   for the whole walk. A stalled receiver holds the result register and stops
//   the walk at the next result. Reset empties the walk state and clears both
//   registers; the matrix and labels hold nothing defined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_first_visit_order #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned WEIGHT_BITS  = 16,
  parameter int unsigned LABEL_BITS   = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire dfvo_pkg::in_req_t  in_req_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      dfvo_pkg::out_rsp_t out_rsp_o
);

  dfvo_pkg::cmd_t    cmd;
  dfvo_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  // Controller.
  dfvo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  dfvo_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .LABEL_BITS   (LABEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // A valid start request locks out further requests on the next cycle.
  a_start_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && status.start_ok) |=> in_stall_o)
    else $error("start request did not lock the request channel");

  // A neighbor found by the scan is pushed on the next cycle.
  a_push_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan && status.found) |=> cmd.push)
    else $error("found neighbor was not pushed");

  // A pop never happens on an empty stack.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !status.depth_zero)
    else $error("stack pop on an empty stack");

  // An error result is always the final result.
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.bad_origin) |-> out_rsp_o.last)
    else $error("bad origin result without last flag");

endmodule

`default_nettype wire
